### rtl/bpa_pkg.sv
// shared types, codes and helpers of the buddy page allocator
package bpa_pkg;

    localparam int ORDER_W = 4;
    localparam int CALC_W  = 17;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int STAT_W  = 2;

    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD     = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_F_RD,
        S_F_CK,
        S_C_RD,
        S_C_CK,
        S_M_RD,
        S_M_CK,
        S_A_SCAN,
        S_A_GOT,
        S_SPLIT,
        S_PS,
        S_PS_H,
        S_UL_WB,
        S_UL_P,
        S_UL_N0,
        S_UL_N,
        S_DONE
    } t_state;

    // smallest order whose block holds n pages, saturating at 15
    function automatic logic [ORDER_W-1:0] order_for(input logic [COUNT_W-1:0] n);
        logic [ORDER_W-1:0] r;
        r = 4'd15;
        for (int o = 15; o >= 0; o--) begin
            if ((CALC_W'(1) << o) >= CALC_W'(n)) begin
                r = ORDER_W'(o);
            end
        end
        return r;
    endfunction

endpackage

### rtl/bpa_ram.sv
// generic single write, single registered read port ram
module bpa_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

### rtl/buddy_page_allocator.sv
// buddy page allocator: top level with page table ram and request sequencer
// alloc: scan the free lists, unlink the block, then split it level by level; free: check the range,
//   check for covering blocks, then merge; init sweeps the page table; the result goes out through a register
// one request in flight at a time; o_in_stall is high whenever the sequencer is not idle
// after reset the page table is swept with o_in_stall high
// the result register lets a new request start while the last result waits
module buddy_page_allocator #(
    parameter int PAGES     = 1024,
    parameter int TOP_ORDER = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bpa_pkg::KIND_W-1:0]    i_kind,
    input  logic [bpa_pkg::COUNT_W-1:0]   i_page_count,
    input  logic [bpa_pkg::INDEX_W-1:0]   i_page_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bpa_pkg::STAT_W-1:0]    o_status,
    output logic [bpa_pkg::INDEX_W-1:0]   o_block_index,
    output logic [bpa_pkg::COUNT_W-1:0]   o_free_total
);

    localparam int AW     = $clog2(PAGES);
    localparam int LW     = $clog2(PAGES + 1);
    localparam int OW_    = bpa_pkg::ORDER_W;
    localparam int W      = bpa_pkg::CALC_W;
    localparam int DW     = 1 + OW_ + 2 * LW;
    localparam int ORDERS = TOP_ORDER + 1;
    localparam int HW     = $clog2(ORDERS);
    localparam int CAP    = (LW - 1 < TOP_ORDER) ? (LW - 1) : TOP_ORDER;
    localparam logic [LW-1:0]  NIL      = LW'(PAGES);
    localparam logic [AW-1:0]  LAST_PG  = AW'(PAGES - 1);
    localparam logic [OW_-1:0] TOP_O    = OW_'(TOP_ORDER);
    localparam logic [OW_-1:0] CAP_O    = OW_'(CAP);

    bpa_pkg::t_state r_state, n_state;

    logic [1:0]     r_kind, n_kind;
    logic [1:0]     r_status, n_status;
    logic [OW_-1:0] r_o, n_o;
    logic [OW_-1:0] r_c, n_c;
    logic [4:0]     r_k, n_k;
    logic [AW-1:0]  r_p, n_p;
    logic [AW-1:0]  r_blk, n_blk;
    logic [AW-1:0]  r_idx, n_idx;
    logic [AW-1:0]  r_last, n_last;
    logic [AW-1:0]  r_buddy, n_buddy;
    logic [AW-1:0]  r_uaddr, n_uaddr;
    logic [OW_-1:0] r_uo, n_uo;
    logic [LW-1:0]  r_up, n_up;
    logic [LW-1:0]  r_un, n_un;
    logic [OW_-1:0] r_po, n_po;
    logic [AW-1:0]  r_pb, n_pb;
    logic [LW-1:0]  r_h, n_h;
    logic [OW_-1:0] r_region, n_region;
    logic [LW-1:0]  r_head [ORDERS];
    logic [LW-1:0]  n_head [ORDERS];
    logic [W-1:0]   r_free_total, n_free_total;
    logic [AW-1:0]  r_sweep, n_sweep;
    logic           r_init, n_init;
    logic           r_out_valid, n_out_valid;
    logic [1:0]     r_out_status, n_out_status;
    logic [9:0]     r_out_blk, n_out_blk;
    logic [10:0]    r_out_total, n_out_total;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [DW-1:0]  ram_wdata, ram_rdata;

    logic           rd_free;
    logic [OW_-1:0] rd_order;
    logic [LW-1:0]  rd_next, rd_prev;

    logic [OW_-1:0] t_ord;
    logic [W-1:0]   t_pw, t_size, t_tmp;
    logic [LW-1:0]  t_h;
    logic [OW_-1:0] t_nc;

    bpa_ram #(
        .DATA_W (DW),
        .DEPTH  (PAGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_free  = ram_rdata[DW-1];
    assign rd_order = ram_rdata[DW-2 -: OW_];
    assign rd_next  = ram_rdata[2*LW-1:LW];
    assign rd_prev  = ram_rdata[LW-1:0];

    assign o_in_stall    = (r_state != bpa_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_block_index = r_out_blk;
    assign o_free_total  = r_out_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bpa_pkg::S_CLEAR;
            r_sweep      <= '0;
            r_init       <= 1'b0;
            r_region     <= '0;
            r_free_total <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < ORDERS; i++) begin
                r_head[i] <= NIL;
            end
        end else begin
            r_state      <= n_state;
            r_sweep      <= n_sweep;
            r_init       <= n_init;
            r_region     <= n_region;
            r_free_total <= n_free_total;
            r_out_valid  <= n_out_valid;
            r_head       <= n_head;
        end
        r_kind       <= n_kind;
        r_status     <= n_status;
        r_o          <= n_o;
        r_c          <= n_c;
        r_k          <= n_k;
        r_p          <= n_p;
        r_blk        <= n_blk;
        r_idx        <= n_idx;
        r_last       <= n_last;
        r_buddy      <= n_buddy;
        r_uaddr      <= n_uaddr;
        r_uo         <= n_uo;
        r_up         <= n_up;
        r_un         <= n_un;
        r_po         <= n_po;
        r_pb         <= n_pb;
        r_h          <= n_h;
        r_out_status <= n_out_status;
        r_out_blk    <= n_out_blk;
        r_out_total  <= n_out_total;
    end

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_status     = r_status;
        n_o          = r_o;
        n_c          = r_c;
        n_k          = r_k;
        n_p          = r_p;
        n_blk        = r_blk;
        n_idx        = r_idx;
        n_last       = r_last;
        n_buddy      = r_buddy;
        n_uaddr      = r_uaddr;
        n_uo         = r_uo;
        n_up         = r_up;
        n_un         = r_un;
        n_po         = r_po;
        n_pb         = r_pb;
        n_h          = r_h;
        n_region     = r_region;
        n_head       = r_head;
        n_free_total = r_free_total;
        n_sweep      = r_sweep;
        n_init       = r_init;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_blk    = r_out_blk;
        n_out_total  = r_out_total;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        t_ord  = bpa_pkg::order_for(i_page_count);
        t_pw   = W'(i_page_index);
        t_size = W'(1) << t_ord;
        t_tmp  = '0;
        t_h    = r_head[r_po[HW-1:0]];
        t_nc   = r_c - 1'b1;

        case (r_state)
            bpa_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = '0;
                if (r_sweep == LAST_PG) begin
                    n_sweep = '0;
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_po    = r_region;
                        n_pb    = '0;
                        n_state = bpa_pkg::S_PS;
                    end else begin
                        n_state = bpa_pkg::S_IDLE;
                    end
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end

            bpa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_kind   = i_kind;
                    n_status = bpa_pkg::ST_OK;
                    n_o      = t_ord;
                    n_c      = t_ord;
                    n_state  = bpa_pkg::S_DONE;
                    case (i_kind)
                        bpa_pkg::KIND_INIT: begin
                            if (i_page_count == '0) begin
                                n_status = bpa_pkg::ST_BAD;
                            end else begin
                                n_region     = (t_ord < CAP_O) ? t_ord : CAP_O;
                                n_free_total = '0;
                                for (int i = 0; i < ORDERS; i++) begin
                                    n_head[i] = NIL;
                                end
                                n_init  = 1'b1;
                                n_sweep = '0;
                                n_state = bpa_pkg::S_CLEAR;
                            end
                        end
                        bpa_pkg::KIND_ALLOC: begin
                            if (i_page_count == '0) begin
                                n_status = bpa_pkg::ST_BAD;
                            end else if (t_ord > r_region) begin
                                n_status = bpa_pkg::ST_NOSPACE;
                            end else begin
                                n_state = bpa_pkg::S_A_SCAN;
                            end
                        end
                        bpa_pkg::KIND_FREE: begin
                            if (i_page_count == '0 || t_ord > r_region
                                || (t_pw & (t_size - 1'b1)) != '0
                                || (t_pw + t_size) > (W'(1) << r_region)) begin
                                n_status = bpa_pkg::ST_BAD;
                            end else begin
                                t_tmp   = t_pw + t_size - 1'b1;
                                n_p     = t_pw[AW-1:0];
                                n_idx   = t_pw[AW-1:0];
                                n_last  = t_tmp[AW-1:0];
                                n_state = bpa_pkg::S_F_RD;
                            end
                        end
                        default: begin
                            n_status = bpa_pkg::ST_BAD;
                        end
                    endcase
                end
            end

            // no free block may start inside the range
            bpa_pkg::S_F_RD: begin
                ram_raddr = r_idx;
                n_state   = bpa_pkg::S_F_CK;
            end

            bpa_pkg::S_F_CK: begin
                if (rd_free) begin
                    n_status = bpa_pkg::ST_BAD;
                    n_state  = bpa_pkg::S_DONE;
                end else if (r_idx == r_last) begin
                    n_k     = 5'(r_o) + 5'd1;
                    n_state = bpa_pkg::S_C_RD;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = bpa_pkg::S_F_RD;
                end
            end

            // no larger free block may already cover the range
            bpa_pkg::S_C_RD: begin
                if (r_k > 5'(r_region)) begin
                    n_state = bpa_pkg::S_M_RD;
                end else begin
                    t_tmp     = W'(r_p) & ~((W'(1) << r_k) - 1'b1);
                    ram_raddr = t_tmp[AW-1:0];
                    n_state   = bpa_pkg::S_C_CK;
                end
            end

            bpa_pkg::S_C_CK: begin
                if (rd_free && rd_order == r_k[OW_-1:0]) begin
                    n_status = bpa_pkg::ST_BAD;
                    n_state  = bpa_pkg::S_DONE;
                end else begin
                    n_k     = r_k + 5'd1;
                    n_state = bpa_pkg::S_C_RD;
                end
            end

            bpa_pkg::S_M_RD: begin
                if (r_o < r_region) begin
                    t_tmp     = W'(r_p) ^ (W'(1) << r_o);
                    ram_raddr = t_tmp[AW-1:0];
                    n_buddy   = t_tmp[AW-1:0];
                    n_state   = bpa_pkg::S_M_CK;
                end else begin
                    n_po    = r_o;
                    n_pb    = r_p;
                    n_state = bpa_pkg::S_PS;
                end
            end

            bpa_pkg::S_M_CK: begin
                if (rd_free && rd_order == r_o) begin
                    n_uaddr = r_buddy;
                    n_uo    = rd_order;
                    n_up    = rd_prev;
                    n_un    = rd_next;
                    n_state = bpa_pkg::S_UL_WB;
                end else begin
                    n_po    = r_o;
                    n_pb    = r_p;
                    n_state = bpa_pkg::S_PS;
                end
            end

            bpa_pkg::S_A_SCAN: begin
                if (r_head[r_c[HW-1:0]] != NIL) begin
                    n_blk     = r_head[r_c[HW-1:0]][AW-1:0];
                    ram_raddr = r_head[r_c[HW-1:0]][AW-1:0];
                    n_state   = bpa_pkg::S_A_GOT;
                end else if (r_c == TOP_O) begin
                    n_status = bpa_pkg::ST_NOSPACE;
                    n_state  = bpa_pkg::S_DONE;
                end else begin
                    n_c = r_c + 1'b1;
                end
            end

            bpa_pkg::S_A_GOT: begin
                n_uaddr = r_blk;
                n_uo    = rd_order;
                n_up    = rd_prev;
                n_un    = rd_next;
                n_state = bpa_pkg::S_UL_WB;
            end

            // hand the upper half of each split to its list
            bpa_pkg::S_SPLIT: begin
                if (r_c > r_o) begin
                    t_tmp   = W'(r_blk) + (W'(1) << t_nc);
                    n_c     = t_nc;
                    n_po    = t_nc;
                    n_pb    = t_tmp[AW-1:0];
                    n_state = bpa_pkg::S_PS;
                end else begin
                    n_state = bpa_pkg::S_DONE;
                end
            end

            bpa_pkg::S_PS: begin
                ram_we    = 1'b1;
                ram_waddr = r_pb;
                ram_wdata = {1'b1, r_po, t_h, NIL};
                n_head[r_po[HW-1:0]] = LW'(r_pb);
                n_free_total = r_free_total + (W'(1) << r_po);
                n_h = t_h;
                if (t_h != NIL) begin
                    ram_raddr = t_h[AW-1:0];
                    n_state   = bpa_pkg::S_PS_H;
                end else if (r_kind == bpa_pkg::KIND_ALLOC) begin
                    n_state = bpa_pkg::S_SPLIT;
                end else begin
                    n_state = bpa_pkg::S_DONE;
                end
            end

            bpa_pkg::S_PS_H: begin
                ram_we    = 1'b1;
                ram_waddr = r_h[AW-1:0];
                ram_wdata = {rd_free, rd_order, rd_next, LW'(r_pb)};
                n_state   = (r_kind == bpa_pkg::KIND_ALLOC) ? bpa_pkg::S_SPLIT
                                                            : bpa_pkg::S_DONE;
            end

            bpa_pkg::S_UL_WB: begin
                ram_we    = 1'b1;
                ram_waddr = r_uaddr;
                ram_wdata = {1'b0, r_uo, r_un, r_up};
                n_free_total = r_free_total - (W'(1) << r_uo);
                if (r_up != NIL) begin
                    ram_raddr = r_up[AW-1:0];
                    n_state   = bpa_pkg::S_UL_P;
                end else begin
                    n_head[r_uo[HW-1:0]] = r_un;
                    n_state = bpa_pkg::S_UL_N0;
                end
            end

            bpa_pkg::S_UL_P: begin
                ram_we    = 1'b1;
                ram_waddr = r_up[AW-1:0];
                ram_wdata = {rd_free, rd_order, r_un, rd_prev};
                n_state   = bpa_pkg::S_UL_N0;
            end

            bpa_pkg::S_UL_N0: begin
                if (r_un != NIL) begin
                    ram_raddr = r_un[AW-1:0];
                    n_state   = bpa_pkg::S_UL_N;
                end else if (r_kind == bpa_pkg::KIND_ALLOC) begin
                    n_state = bpa_pkg::S_SPLIT;
                end else begin
                    if (r_buddy < r_p) begin
                        n_p = r_buddy;
                    end
                    n_o     = r_o + 1'b1;
                    n_state = bpa_pkg::S_M_RD;
                end
            end

            bpa_pkg::S_UL_N: begin
                ram_we    = 1'b1;
                ram_waddr = r_un[AW-1:0];
                ram_wdata = {rd_free, rd_order, rd_next, r_up};
                if (r_kind == bpa_pkg::KIND_ALLOC) begin
                    n_state = bpa_pkg::S_SPLIT;
                end else begin
                    if (r_buddy < r_p) begin
                        n_p = r_buddy;
                    end
                    n_o     = r_o + 1'b1;
                    n_state = bpa_pkg::S_M_RD;
                end
            end

            bpa_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    t_tmp        = W'(r_blk);
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_blk    = (r_kind == bpa_pkg::KIND_ALLOC && r_status == bpa_pkg::ST_OK)
                                   ? t_tmp[9:0] : 10'd0;
                    n_out_total  = r_free_total[10:0];
                    n_state      = bpa_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase
    end

    // the free page count never exceeds the region size while idle
    a_total_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bpa_pkg::S_IDLE |-> r_free_total <= (W'(1) << r_region))
        else $error("free total exceeds region");

    // no new transaction is taken while the page table is swept
    a_stall_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bpa_pkg::S_CLEAR |-> o_in_stall)
        else $error("input open during sweep");

    // failed requests report block index zero
    a_blk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != bpa_pkg::ST_OK |-> o_block_index == '0)
        else $error("block index set on failure");

    // a finished result waits while the output register is held
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bpa_pkg::S_DONE && o_out_valid && i_out_stall
        |=> r_state == bpa_pkg::S_DONE)
        else $error("result overwritten");

endmodule
